>>> design/sli_pkg.sv
// Package with shared constants and types for the sorted list block.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_LISTED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LIST   = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_LST_RD,
    S_LST_OUT,
    S_RESP
  } state_t;

endpackage

>>> design/sorted_list_insert_and_dump.sv
// Bounded sorted list of signed values with insert and in-order dump.
//
//   channel | ports          | tdata (low bit up) | tuser (low bit up) | tlast
//   --------+----------------+--------------------+--------------------+------------
//   in      | in_t*          | new_value [31:0]   | command [0]        | -
//   out     | out_t*         | element_value      | status [1:0]       | last_of_run
//
// One item is handled at a time; in_tready is high only while the sequencer is idle.
// An insert walks down from the top entry; each step reads an entry (S_INS_RD), then compares
// it and moves it up one place (S_INS_CMP), until a smaller entry or the first entry is reached.
// A list reads and sends each entry in turn; a drop or an empty list gives one response.
// Reset clears the sequencer and the entry count; the memory needs no clearing pass.
// A stalled out_tready holds the output register and the sequencer waits for it.
`timescale 1ns / 1ps

module sorted_list_insert_and_dump
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // new_value [31:0]
  input  logic              in_tuser,   // command [0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // element_value [31:0]
  output logic [1:0]        out_tuser,  // status [1:0]
  output logic              out_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] mem [CAPACITY];

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  status_t                  resp_r, resp_nxt;
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;

  logic                     we;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free;
  logic                     last_elem;

  assign out_free  = !out_valid_r || out_tready;
  assign last_elem = (CW'(idx_r) + CW'(1)) == count_r;
  assign rd_addr   = (state_r == S_INS_RD) ? (idx_r - AW'(1)) : idx_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    resp_r       <= resp_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    resp_nxt       = resp_r;
    we             = 1'b0;
    wr_addr        = idx_r;
    wr_data        = val_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          val_nxt = in_tdata;
          if (in_tuser == CMD_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              resp_nxt  = ST_DROPPED;
              state_nxt = S_RESP;
            end else begin
              idx_nxt   = count_r[AW-1:0];
              state_nxt = S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_LST_RD;
            end
          end
        end
      end

      S_INS_RD: begin
        // At the bottom of the list the new value lands in the first entry.
        if (idx_r == '0) begin
          we        = 1'b1;
          wr_addr   = '0;
          wr_data   = val_r;
          count_nxt = count_r + CW'(1);
          resp_nxt  = ST_INSERTED;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        we      = 1'b1;
        wr_addr = idx_r;
        if (rd_data_r < val_r) begin
          wr_data   = val_r;
          count_nxt = count_r + CW'(1);
          resp_nxt  = ST_INSERTED;
          state_nxt = S_RESP;
        end else begin
          // Entry is not smaller: move it up one place and keep walking down.
          wr_data   = rd_data_r;
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_INS_RD;
        end
      end

      S_LST_RD: begin
        state_nxt = S_LST_OUT;
      end

      S_LST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = rd_data_r;
          out_status_nxt = ST_LISTED;
          out_last_nxt   = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_LST_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = resp_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> tb/tb_sorted_list_insert_and_dump.sv
// Self-checking testbench for the sorted list block: directed table, random traffic, shadow list.
`timescale 1ns / 1ps

module tb_sorted_list_insert_and_dump;
  import sli_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 206;
  localparam int TAIL_CYCLES  = 2 * LIST_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic        last;
  } reply_t;

  typedef struct packed {
    command_t    cmd;
    logic [31:0] value;
    logic        typed;
    status_t     status;
  } row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // new_value [31:0]
  logic              in_tuser   = 1'b0;  // command [0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;  // element_value [31:0]
  logic [1:0]        out_tuser;  // status [1:0]
  logic              out_tlast;

  // Shadow copy of the list contents, kept in ascending signed order.
  logic signed [31:0] shadow_list [$];
  reply_t             step_replies [$];
  reply_t             replies_due [$];

  int errors        = 0;
  int cycles        = 0;
  int replies_seen  = 0;
  int inserts_sent  = 0;
  int lists_sent    = 0;
  int drops_seen    = 0;
  int listed_seen   = 0;
  int burst_left    = 0;
  int ready_mode    = 0;
  int ready_left    = 0;

  // Rows with a typed status give the expected status directly; the other rows are predicted.
  row_t directed_rows [0:23] = '{
    '{CMD_LIST,   32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_INSERTED},
    '{CMD_LIST,   32'h0000_0000, 1'b0, ST_LISTED},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h0000_0001, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, ST_INSERTED},
    '{CMD_LIST,   32'hA5A5_A5A5, 1'b0, ST_LISTED},
    '{CMD_INSERT, 32'h8000_0001, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h7FFF_FFFE, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h0001_0000, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'hFFFF_0000, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h5555_5555, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'hAAAA_AAAA, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h0000_0002, 1'b1, ST_INSERTED},
    '{CMD_LIST,   32'h0000_0000, 1'b0, ST_LISTED},
    '{CMD_INSERT, 32'hFFFF_FFFE, 1'b1, ST_INSERTED},
    '{CMD_INSERT, 32'h1234_5678, 1'b1, ST_DROPPED},
    '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_DROPPED},
    '{CMD_LIST,   32'h0000_0000, 1'b0, ST_LISTED},
    '{CMD_LIST,   32'hFFFF_FFFF, 1'b0, ST_LISTED}
  };

  sorted_list_insert_and_dump #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: switches between always ready, coin-flip ready and long stalls.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= int'($urandom_range(0, 2));
      ready_left <= int'($urandom_range(20, 80));
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  function automatic void apply_to_shadow(command_t cmd, logic [31:0] value);
    int pos;
    step_replies.delete();
    if (cmd == CMD_INSERT) begin
      if (shadow_list.size() >= LIST_DEPTH) begin
        step_replies.push_back(reply_t'{ST_DROPPED, 32'h0, 1'b1});
      end else begin
        // New value goes ahead of the first entry that is not smaller.
        pos = 0;
        while (pos < shadow_list.size() && shadow_list[pos] < $signed(value)) pos++;
        shadow_list.insert(pos, $signed(value));
        step_replies.push_back(reply_t'{ST_INSERTED, 32'h0, 1'b1});
      end
    end else if (shadow_list.size() == 0) begin
      step_replies.push_back(reply_t'{ST_EMPTY, 32'h0, 1'b1});
    end else begin
      foreach (shadow_list[i]) begin
        step_replies.push_back(reply_t'{ST_LISTED, shadow_list[i],
                                        i == shadow_list.size() - 1});
      end
    end
  endfunction

  task automatic send_item(command_t cmd, logic [31:0] value, logic typed, status_t status);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    apply_to_shadow(cmd, value);
    if (typed) begin
      replies_due.push_back(reply_t'{status, 32'h0, 1'b1});
    end else begin
      foreach (step_replies[i]) replies_due.push_back(step_replies[i]);
    end
    if (cmd == CMD_INSERT) inserts_sent++;
    else lists_sent++;
  endtask

  // Sender runs in bursts; between bursts it drops valid.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    gap = $urandom_range(1, 6);
    in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (out_tuser == ST_DROPPED) drops_seen++;
      if (out_tuser == ST_LISTED) listed_seen++;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("unexpected transaction: status %0d value %h",
                                          out_tuser, out_tdata);
      end else begin
        want = replies_due.pop_front();
        if (out_tuser !== want.status) begin
          errors++;
          if (errors <= MAX_REPORTS) $error("status: expected %0d, got %0d",
                                            want.status, out_tuser);
        end
        if (out_tdata !== want.value) begin
          errors++;
          if (errors <= MAX_REPORTS) $error("element_value: expected %h, got %h",
                                            want.value, out_tdata);
        end
        if (out_tlast !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) $error("last_of_run: expected %0b, got %0b",
                                            want.last, out_tlast);
        end
      end
    end
  end

  initial begin
    command_t    cmd;
    logic [31:0] value;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].status);
      pace_sender();
    end

    // Hold off once until the list has answered everything so far.
    drain_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = ($urandom_range(0, 99) < 55) ? CMD_LIST : CMD_INSERT;
      case ($urandom_range(0, 7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'h0000_0000;
        3: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_item(cmd, value, 1'b0, ST_INSERTED);
      if ($urandom_range(0, 29) == 0) drain_replies();
      else pace_sender();
    end

    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d inserts and %0d list commands; checked %0d result transactions.",
             inserts_sent, lists_sent, replies_seen);
    $display("List held %0d entries at the end; %0d inserts dropped, %0d elements listed.",
             shadow_list.size(), drops_seen, listed_seen);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sli_pkg.sv
design/sorted_list_insert_and_dump.sv
tb/tb_sorted_list_insert_and_dump.sv
